// ===== hw/rtl/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;
  localparam int unsigned MinDim     = 3;
  localparam int unsigned DimResetVal = 16;

  localparam logic [1:0] OpRestart = 2'd0;
  localparam logic [1:0] OpStep    = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;

  localparam logic [1:0] DirNorth = 2'd0;
  localparam logic [1:0] DirSouth = 2'd1;
  localparam logic [1:0] DirEast  = 2'd2;
  localparam logic [1:0] DirWest  = 2'd3;

  localparam logic RegRows = 1'b0;
  localparam logic RegCols = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] rand_value;
    logic [5:0]  query_row;
    logic [5:0]  query_col;
  } dmc_in_t;

  typedef struct packed {
    logic       carved;
    logic [5:0] from_row;
    logic [5:0] from_col;
    logic [5:0] to_row;
    logic [5:0] to_col;
    logic [1:0] carve_dir;
    logic       done_res;
    logic [3:0] walls;
  } dmc_out_t;

  typedef struct packed {
    logic       found;
    logic [1:0] dir;
  } dmc_pick_t;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_TOP  = 9'b000000100,
    S_SCAN = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_PICK = 9'b000100000,
    S_PUSH = 9'b001000000,
    S_QRY  = 9'b010000000,
    S_OUT  = 9'b100000000
  } dmc_state_e;

  // base-4 digit sum, since 4 = 1 (mod 3)
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dmc_cfg_regs.sv =====
`default_nettype none

module dmc_cfg_regs #(
  parameter int unsigned MaxRows = dmc_pkg::MaxRowsDef,
  parameter int unsigned MaxCols = dmc_pkg::MaxColsDef,
  parameter int unsigned DimW    = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic      [DimW-1:0] rows_o,
  output logic      [DimW-1:0] cols_o
);
  import dmc_pkg::*;

  logic [6:0] rows_q;
  logic [6:0] cols_q;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'(DimResetVal);
      cols_q <= 7'(DimResetVal);
    end else if (wr_en) begin
      if (paddr[2] == RegRows) begin
        rows_q <= pwdata[6:0];
      end else begin
        cols_q <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegRows) ? {25'd0, rows_q} : {25'd0, cols_q};

  function automatic logic [DimW-1:0] clamp(input logic [6:0] v, input logic [DimW-1:0] hi);
    logic [DimW-1:0] w;
    w = DimW'(v);
    if (w < DimW'(MinDim)) begin
      return DimW'(MinDim);
    end else if (w > hi) begin
      return hi;
    end
    return w;
  endfunction

  assign rows_o = clamp(rows_q, DimW'(MaxRows));
  assign cols_o = clamp(cols_q, DimW'(MaxCols));

endmodule

`default_nettype wire

// ===== hw/rtl/dmc_nbr_pick.sv =====
`default_nettype none

module dmc_nbr_pick #(
  parameter int unsigned RowW = 6,
  parameter int unsigned ColW = 6,
  parameter int unsigned DimW = 7
) (
  input  wire logic [RowW-1:0] top_row_i,
  input  wire logic [ColW-1:0] top_col_i,
  input  wire logic [DimW-1:0] rows_i,
  input  wire logic [DimW-1:0] cols_i,
  input  wire logic [3:0]      nbr_visited_i,
  input  wire logic [1:0]      rand_lo_i,
  input  wire logic [1:0]      rand_mod3_i,
  output dmc_pkg::dmc_pick_t   pick_o
);
  import dmc_pkg::*;

  logic [DimW-1:0] rz;
  logic [DimW-1:0] cz;
  logic [3:0]      cand;
  logic [2:0]      cnt;
  logic [1:0]      sel;
  logic [1:0]      seen;

  assign rz = DimW'(top_row_i);
  assign cz = DimW'(top_col_i);

  always_comb begin
    cand[DirNorth] = (rz != '0) && ((rz - 1'b1) < rows_i) && (cz < cols_i) &&
                     !nbr_visited_i[DirNorth];
    cand[DirSouth] = ((rz + 1'b1) < rows_i) && (cz < cols_i) && !nbr_visited_i[DirSouth];
    cand[DirEast]  = ((cz + 1'b1) < cols_i) && (rz < rows_i) && !nbr_visited_i[DirEast];
    cand[DirWest]  = (cz != '0) && ((cz - 1'b1) < cols_i) && (rz < rows_i) &&
                     !nbr_visited_i[DirWest];
  end

  assign cnt = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

  always_comb begin
    case (cnt)
      3'd2:    sel = {1'b0, rand_lo_i[0]};
      3'd3:    sel = rand_mod3_i;
      3'd4:    sel = rand_lo_i;
      default: sel = 2'd0;
    endcase
  end

  always_comb begin
    seen        = 2'd0;
    pick_o.dir  = DirNorth;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == sel) begin
          pick_o.dir = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
    pick_o.found = (cnt != 3'd0);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfs_maze_carver_unit.sv =====
// Channel   Dir  Handshake          Payload
// in        in   in_valid_i/o stall dmc_in_t  (op, rand_value, query)
// out       out  out_valid_o/i stall dmc_out_t (carve report, done, walls)
// cfg       in   APB psel/penable   grid_rows @0x0, grid_cols @0x4
// One item at a time. A step is set by one read port on the cell memory: the stack top
// is read, then the top cell and its four neighbours, one per cycle.
// Restart is a sweep of the cell memory; after reset the same sweep runs before the first item.
// A result waits in the output register under stall; the next item is taken meanwhile.
`default_nettype none

module dfs_maze_carver_unit #(
  parameter int unsigned MaxRows = dmc_pkg::MaxRowsDef,
  parameter int unsigned MaxCols = dmc_pkg::MaxColsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dmc_pkg::dmc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dmc_pkg::dmc_out_t     out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  import dmc_pkg::*;

  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned CellAw    = RowW + ColW;
  localparam int unsigned CellDepth = 1 << CellAw;
  localparam int unsigned CellCount = MaxRows * MaxCols;
  localparam int unsigned DepthW    = $clog2(CellCount + 1);
  localparam int unsigned DimA      = (RowW + 1 > ColW + 1) ? RowW + 1 : ColW + 1;
  localparam int unsigned DimW      = (DimA > 7) ? DimA : 7;

  dmc_state_e state_q, state_d;

  logic [DimW-1:0]   rows, cols;
  logic [2:0]        scan_q, scan_d;
  logic [CellAw-1:0] clr_addr_q, clr_addr_d;
  logic              clr_res_q, clr_res_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              out_valid_q;
  logic              out_load;

  logic [CellAw-1:0] top_q, top_d;
  logic [3:0]        walls_q, walls_d;
  logic [3:0]        nv_q, nv_d;
  logic [1:0]        rlo_q, rlo_d;
  logic [1:0]        rmod3_q, rmod3_d;
  logic              qry_ok_q, qry_ok_d;
  dmc_out_t          res_q, res_d;
  dmc_out_t          out_q;

  logic [4:0]        cell_mem [CellDepth];
  logic              cell_we;
  logic [CellAw-1:0] cell_waddr, cell_raddr;
  logic [4:0]        cell_wdata, cell_rdata_q;

  logic [CellAw-1:0] stk_mem [CellDepth];
  logic              stk_we;
  logic [CellAw-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_q;

  logic [RowW-1:0]   top_r, tgt_r;
  logic [ColW-1:0]   top_c, tgt_c;
  logic [CellAw-1:0] tgt_addr;
  logic [3:0]        dir_mask, opp_mask;
  dmc_pick_t         pick;

  dmc_cfg_regs #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols),
    .DimW    (DimW)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .rows_o  (rows),
    .cols_o  (cols)
  );

  assign pready = 1'b1;

  assign top_r = top_q[CellAw-1:ColW];
  assign top_c = top_q[ColW-1:0];

  dmc_nbr_pick #(
    .RowW (RowW),
    .ColW (ColW),
    .DimW (DimW)
  ) u_pick (
    .top_row_i     (top_r),
    .top_col_i     (top_c),
    .rows_i        (rows),
    .cols_i        (cols),
    .nbr_visited_i (nv_q),
    .rand_lo_i     (rlo_q),
    .rand_mod3_i   (rmod3_q),
    .pick_o        (pick)
  );

  always_comb begin
    tgt_r = top_r;
    tgt_c = top_c;
    case (pick.dir)
      DirNorth: tgt_r = top_r - 1'b1;
      DirSouth: tgt_r = top_r + 1'b1;
      DirEast:  tgt_c = top_c + 1'b1;
      default:  tgt_c = top_c - 1'b1;
    endcase
  end

  assign tgt_addr = {tgt_r, tgt_c};
  assign dir_mask = 4'b0001 << pick.dir;
  assign opp_mask = 4'b0001 << (pick.dir ^ 2'b01);

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    clr_addr_d = clr_addr_q;
    clr_res_d  = clr_res_q;
    depth_d    = depth_q;
    top_d      = top_q;
    walls_d    = walls_q;
    nv_d       = nv_q;
    rlo_d      = rlo_q;
    rmod3_d    = rmod3_q;
    qry_ok_d   = qry_ok_q;
    res_d      = res_q;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    cell_we    = 1'b0;
    cell_waddr = top_q;
    cell_wdata = '0;
    cell_raddr = top_q;
    stk_we     = 1'b0;
    stk_waddr  = CellAw'(depth_q);
    stk_wdata  = tgt_addr;
    stk_raddr  = CellAw'(depth_q - 1'b1);

    case (state_q)
      S_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr_q;
        cell_wdata = {clr_res_q && (clr_addr_q == '0), 4'hF};
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          if (clr_res_q) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
            depth_d   = DepthW'(1);
            state_d   = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        cell_raddr = {RowW'(in_data_i.query_row), ColW'(in_data_i.query_col)};
        if (in_valid_i) begin
          res_d    = '0;
          rlo_d    = in_data_i.rand_value[1:0];
          rmod3_d  = mod3_16(in_data_i.rand_value);
          qry_ok_d = (9'(in_data_i.query_row) < 9'(MaxRows)) &&
                     (9'(in_data_i.query_col) < 9'(MaxCols));
          case (in_data_i.op)
            OpRestart: begin
              clr_res_d  = 1'b1;
              clr_addr_d = '0;
              state_d    = S_CLR;
            end
            OpStep: begin
              if (depth_q == '0) begin
                res_d.done_res = 1'b1;
                state_d        = S_OUT;
              end else begin
                state_d = S_TOP;
              end
            end
            OpRead:  state_d = S_QRY;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_TOP: begin
        top_d   = stk_rdata_q;
        scan_d  = 3'd0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        case (scan_q)
          3'd0:    cell_raddr = top_q;
          3'd1:    cell_raddr = {top_r - 1'b1, top_c};
          3'd2:    cell_raddr = {top_r + 1'b1, top_c};
          3'd3:    cell_raddr = {top_r, top_c + 1'b1};
          default: cell_raddr = {top_r, top_c - 1'b1};
        endcase
        if (scan_q == 3'd1) begin
          walls_d = cell_rdata_q[3:0];
        end else if (scan_q != 3'd0) begin
          nv_d[2'(scan_q - 3'd2)] = cell_rdata_q[4];
        end
        scan_d = scan_q + 3'd1;
        if (scan_q == 3'd4) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        nv_d[DirWest] = cell_rdata_q[4];
        state_d       = S_PICK;
      end
      S_PICK: begin
        if (!pick.found || (depth_q >= DepthW'(CellCount))) begin
          depth_d = depth_q - 1'b1;
          state_d = S_OUT;
        end else begin
          cell_we         = 1'b1;
          cell_waddr      = top_q;
          cell_wdata      = {1'b1, walls_q & ~dir_mask};
          res_d.carved    = 1'b1;
          res_d.from_row  = 6'(top_r);
          res_d.from_col  = 6'(top_c);
          res_d.to_row    = 6'(tgt_r);
          res_d.to_col    = 6'(tgt_c);
          res_d.carve_dir = pick.dir;
          state_d         = S_PUSH;
        end
      end
      S_PUSH: begin
        // an unvisited cell still has all four walls
        cell_we    = 1'b1;
        cell_waddr = tgt_addr;
        cell_wdata = {1'b1, 4'hF & ~opp_mask};
        stk_we     = 1'b1;
        stk_waddr  = CellAw'(depth_q);
        stk_wdata  = tgt_addr;
        depth_d    = depth_q + 1'b1;
        state_d    = S_OUT;
      end
      S_QRY: begin
        res_d.walls = qry_ok_q ? cell_rdata_q[3:0] : 4'hF;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      scan_q      <= '0;
      clr_addr_q  <= '0;
      clr_res_q   <= 1'b0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      clr_addr_q <= clr_addr_d;
      clr_res_q  <= clr_res_d;
      depth_q    <= depth_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    walls_q  <= walls_d;
    nv_q     <= nv_d;
    rlo_q    <= rlo_d;
    rmod3_q  <= rmod3_d;
    qry_ok_q <= qry_ok_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dmc_checker.sv =====
`default_nettype none

module dmc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire dmc_pkg::dmc_out_t out_data_o
);
  import dmc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  a_carve_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.carved |-> !out_data_o.done_res && (out_data_o.walls == 4'h0))
    else $error("carve result also flags done or walls");

  a_vert_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.carved &&
    (out_data_o.carve_dir == DirNorth || out_data_o.carve_dir == DirSouth) |->
    out_data_o.to_col == out_data_o.from_col &&
    (out_data_o.to_row == out_data_o.from_row + 6'd1 ||
     out_data_o.to_row == out_data_o.from_row - 6'd1))
    else $error("vertical carve to a non-adjacent cell");

  a_horz_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.carved &&
    (out_data_o.carve_dir == DirEast || out_data_o.carve_dir == DirWest) |->
    out_data_o.to_row == out_data_o.from_row &&
    (out_data_o.to_col == out_data_o.from_col + 6'd1 ||
     out_data_o.to_col == out_data_o.from_col - 6'd1))
    else $error("horizontal carve to a non-adjacent cell");

endmodule

bind dfs_maze_carver_unit dmc_checker u_dmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/dfs_maze_carver_unit_tb.sv =====
`default_nettype none

module dfs_maze_carver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  localparam int Cells = MaxRowsDef * MaxColsDef;
  localparam int QuietLimit = 20000;
  localparam int SettleCycles = 50;
  localparam int RandomItems = 1150;
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  dmc_in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  dmc_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // maze state as the block should hold it
  logic [3:0] cell_walls [Cells];
  bit cell_seen [Cells];
  logic [11:0] path_cells [Cells];
  int path_depth;
  logic [6:0] rows_reg;
  logic [6:0] cols_reg;

  dmc_out_t carve_reports_due [$];
  dmc_out_t due_head;
  int err_cnt = 0;
  int quiet_cycles = 0;
  int hold_len = 0;
  bit idle_on = 1'b1;

  dfs_maze_carver_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [6:0] v, input int hi);
    if (int'(v) < MinDim) return MinDim;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic dmc_out_t carve_predict(input dmc_in_t item);
    dmc_out_t res;
    int rows;
    int cols;
    int top;
    int r;
    int c;
    int cnt;
    int pick;
    int nxt;
    int cand_r [4];
    int cand_c [4];
    logic [1:0] cand_d [4];
    res = '0;
    rows = clamp_dim(rows_reg, MaxRowsDef);
    cols = clamp_dim(cols_reg, MaxColsDef);
    cnt = 0;
    case (item.op)
      OpRestart: begin
        for (int i = 0; i < Cells; i++) begin
          cell_walls[i] = 4'hF;
          cell_seen[i] = 1'b0;
        end
        cell_seen[0] = 1'b1;
        path_cells[0] = '0;
        path_depth = 1;
      end
      OpStep: begin
        if (path_depth == 0) begin
          res.done_res = 1'b1;
        end else begin
          top = int'(path_cells[path_depth - 1]);
          r = top / MaxColsDef;
          c = top % MaxColsDef;
          if (r >= 1 && r - 1 < rows && c < cols && !cell_seen[(r - 1) * MaxColsDef + c]) begin
            cand_r[cnt] = r - 1; cand_c[cnt] = c; cand_d[cnt] = DirNorth; cnt++;
          end
          if (r + 1 < rows && c < cols && !cell_seen[(r + 1) * MaxColsDef + c]) begin
            cand_r[cnt] = r + 1; cand_c[cnt] = c; cand_d[cnt] = DirSouth; cnt++;
          end
          if (c + 1 < cols && r < rows && !cell_seen[r * MaxColsDef + c + 1]) begin
            cand_r[cnt] = r; cand_c[cnt] = c + 1; cand_d[cnt] = DirEast; cnt++;
          end
          if (c >= 1 && c - 1 < cols && r < rows && !cell_seen[r * MaxColsDef + c - 1]) begin
            cand_r[cnt] = r; cand_c[cnt] = c - 1; cand_d[cnt] = DirWest; cnt++;
          end
          if (cnt == 0 || path_depth >= Cells) begin
            path_depth--;
          end else begin
            pick = int'(item.rand_value) % cnt;
            nxt = cand_r[pick] * MaxColsDef + cand_c[pick];
            cell_walls[top][cand_d[pick]] = 1'b0;
            cell_walls[nxt][cand_d[pick] ^ 2'd1] = 1'b0;
            cell_seen[nxt] = 1'b1;
            path_cells[path_depth] = 12'(nxt);
            path_depth++;
            res.carved = 1'b1;
            res.from_row = 6'(r);
            res.from_col = 6'(c);
            res.to_row = 6'(cand_r[pick]);
            res.to_col = 6'(cand_c[pick]);
            res.carve_dir = cand_d[pick];
          end
        end
      end
      OpRead: begin
        res.walls = cell_walls[{item.query_row, item.query_col}];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic dmc_in_t make_item(input logic [1:0] op);
    dmc_in_t t;
    t.op = op;
    t.rand_value = 16'($urandom());
    t.query_row = 6'($urandom());
    t.query_col = 6'($urandom());
    return t;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      $display("MISMATCH %0t ns: %s = %0d, expected %0d", $time, what, got, want);
      err_cnt++;
    end
  endtask

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      carve_reports_due.push_back(carve_predict(in_data));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (carve_reports_due.size() == 0) begin
        compare_field("results pending at output transaction", 0, 1);
      end else begin
        due_head = carve_reports_due.pop_front();
        compare_field("carved", 32'(out_data.carved), 32'(due_head.carved));
        compare_field("from_row", 32'(out_data.from_row), 32'(due_head.from_row));
        compare_field("from_col", 32'(out_data.from_col), 32'(due_head.from_col));
        compare_field("to_row", 32'(out_data.to_row), 32'(due_head.to_row));
        compare_field("to_col", 32'(out_data.to_col), 32'(due_head.to_col));
        compare_field("carve_dir", 32'(out_data.carve_dir), 32'(due_head.carve_dir));
        compare_field("done_res", 32'(out_data.done_res), 32'(due_head.done_res));
        compare_field("walls", 32'(out_data.walls), 32'(due_head.walls));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall per transaction, plus an optional long hold-off
  initial begin
    int n;
    forever begin
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      n = idle_on ? $urandom_range(0, 4) : 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic send_item(input dmc_in_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (carve_reports_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_access(input logic idx, input logic wr, input logic [6:0] val);
    logic [31:0] word;
    word = $urandom();
    word[6:0] = val;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == RegRows) rows_reg = val;
      else cols_reg = val;
    end else begin
      compare_field(idx == RegRows ? "grid_rows readback" : "grid_cols readback",
                    32'(prdata[6:0]), 32'(idx == RegRows ? rows_reg : cols_reg));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid(input logic [6:0] r, input logic [6:0] c);
    settle();
    cfg_access(RegRows, 1'b1, r);
    cfg_access(RegCols, 1'b1, c);
    cfg_access(RegRows, 1'b0, '0);
    cfg_access(RegCols, 1'b0, '0);
  endtask

  task automatic run_steps(input int n);
    for (int k = 0; k < n; k++) begin
      send_item(make_item(OpStep));
      if (path_depth == 0) break;
    end
  endtask

  task automatic test_after_reset();
    dmc_in_t t;
    cfg_access(RegRows, 1'b0, '0);
    cfg_access(RegCols, 1'b0, '0);
    // empty stack: done
    send_item(make_item(OpStep));
    t = make_item(OpStep);
    t.rand_value = '1;
    send_item(t);
    t = make_item(OpRead);
    t.query_row = '0;
    t.query_col = '0;
    send_item(t);
    t.query_row = '1;
    t.query_col = '1;
    send_item(t);
    t.query_row = '0;
    send_item(t);
    send_item(make_item(OpUnused));
    send_item(make_item(OpStep));
  endtask

  task automatic test_small_grid();
    dmc_in_t t;
    set_grid(7'(MinDim), 7'(MinDim));
    send_item(make_item(OpRestart));
    for (int k = 0; k < 18; k++) begin
      t = make_item(OpStep);
      t.rand_value = k[0] ? 16'hFFFF : 16'h0000;
      send_item(t);
      if (k == 5) send_item(make_item(OpUnused));
      if (k == 9) begin
        t = make_item(OpRead);
        t.query_row = 6'd1;
        t.query_col = 6'd1;
        send_item(t);
      end
    end
    t = make_item(OpRead);
    t.query_row = 6'd0;
    t.query_col = 6'd0;
    send_item(t);
    t.query_row = 6'd2;
    t.query_col = 6'd2;
    send_item(t);
  endtask

  task automatic test_clamped_sizes();
    logic [6:0] r_set [4];
    logic [6:0] c_set [4];
    dmc_in_t t;
    r_set = '{7'd0, 7'd127, 7'd64, 7'd2};
    c_set = '{7'd127, 7'd1, 7'd64, 7'd65};
    for (int k = 0; k < 4; k++) begin
      set_grid(r_set[k], c_set[k]);
      send_item(make_item(OpRestart));
      run_steps(20);
      t = make_item(OpRead);
      t.query_row = 6'(clamp_dim(rows_reg, MaxRowsDef) - 1);
      t.query_col = 6'(clamp_dim(cols_reg, MaxColsDef) - 1);
      send_item(t);
      t.query_row = '1;
      t.query_col = '1;
      send_item(t);
    end
  endtask

  // shrink under a running search so stack cells fall outside the grid, then grow
  task automatic test_resize_midway();
    set_grid(7'd8, 7'd8);
    send_item(make_item(OpRestart));
    run_steps(40);
    set_grid(7'd4, 7'd3);
    run_steps(60);
    set_grid(7'd10, 7'd10);
    run_steps(250);
    send_item(make_item(OpStep));
  endtask

  task automatic test_backpressure();
    set_grid(7'd6, 7'd6);
    idle_on = 1'b0;
    send_item(make_item(OpRestart));
    hold_len = 400;
    run_steps(40);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    dmc_in_t t;
    int sent;
    int cap;
    int phase;
    int unsigned dice;
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      dice = $urandom_range(0, 99);
      if (dice < 85) begin
        set_grid(7'($urandom_range(3, 10)), 7'($urandom_range(3, 10)));
      end else if (dice < 95) begin
        set_grid(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end else begin
        set_grid(7'($urandom_range(0, 2)), 7'($urandom_range(64, 127)));
      end
      idle_on = (phase % 4 != 3);
      send_item(make_item(OpRestart));
      sent++;
      cap = sent + 300;
      while (path_depth != 0 && sent < cap) begin
        dice = $urandom_range(0, 99);
        if (dice < 82) begin
          t = make_item(OpStep);
        end else if (dice < 94) begin
          t = make_item(OpRead);
          if (dice < 90) begin
            t.query_row = 6'($urandom_range(0, clamp_dim(rows_reg, MaxRowsDef) - 1));
            t.query_col = 6'($urandom_range(0, clamp_dim(cols_reg, MaxColsDef) - 1));
          end
        end else if (dice < 99) begin
          t = make_item(OpUnused);
        end else begin
          t = make_item(OpRestart);
        end
        send_item(t);
        sent++;
      end
      if (path_depth == 0) begin
        send_item(make_item(OpStep));
        sent++;
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < Cells; i++) begin
      cell_walls[i] = 4'hF;
      cell_seen[i] = 1'b0;
      path_cells[i] = '0;
    end
    path_depth = 0;
    rows_reg = 7'(DimResetVal);
    cols_reg = 7'(DimResetVal);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_small_grid();
    test_clamped_sizes();
    test_resize_midway();
    test_backpressure();
    test_random();

    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_cfg_regs.sv
hw/rtl/dmc_nbr_pick.sv
hw/rtl/dfs_maze_carver_unit.sv
hw/rtl/dmc_checker.sv
tb/dfs_maze_carver_unit_tb.sv
